// ----- rtl/adaptive_quality_ladder_control_assert.svh -----
// assertion macros for the quality ladder controller
`ifndef ADAPTIVE_QUALITY_LADDER_CONTROL_ASSERT_SVH
`define ADAPTIVE_QUALITY_LADDER_CONTROL_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AQLC_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AQLC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/aqlc_pkg.sv -----
// shared types, codes and ladder table for the quality ladder controller
`default_nettype none

package aqlc_pkg;

    // event codes
    localparam logic [1:0] OP_GAIN      = 2'd0;
    localparam logic [1:0] OP_SEND_OK   = 2'd1;
    localparam logic [1:0] OP_SEND_FAIL = 2'd2;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_NIGHT_ENTER,
        CFG_NIGHT_EXIT,
        CFG_NIGHT_CONFIRM,
        CFG_DOWN_PCT,
        CFG_UP_PCT,
        CFG_UP_CLEAN,
        CFG_DAY_INTERVAL,
        CFG_NIGHT_INTERVAL
    } cfg_idx_t;

    localparam int CFG_DATA_W  = 10;
    localparam int LEVEL_MAX_W = 4;
    localparam logic [3:0] TABLE_LAST = 4'd5;
    localparam logic [6:0] AVG_SCALE  = 7'd100;

    typedef struct packed {
        logic [9:0] enter_gain;
        logic [9:0] exit_gain;
        logic [3:0] confirm;
    } profile_cfg_t;

    typedef struct packed {
        logic [9:0] down_pct;
        logic [9:0] up_pct;
        logic [9:0] up_clean;
        logic [7:0] day_int;
        logic [7:0] night_int;
    } ladder_cfg_t;

    typedef struct packed {
        logic       night;
        logic       night_next;
        logic       changed;
        logic [9:0] gain;
    } profile_status_t;

    function automatic logic [1:0] step_size(input logic [3:0] level);
        logic [3:0] idx;
        idx = (level < TABLE_LAST) ? level : TABLE_LAST;
        case (idx)
            4'd0, 4'd1: step_size = 2'd0;
            4'd2:       step_size = 2'd1;
            default:    step_size = 2'd2;
        endcase
    endfunction

    function automatic logic [5:0] step_quality(input logic [3:0] level);
        logic [3:0] idx;
        idx = (level < TABLE_LAST) ? level : TABLE_LAST;
        case (idx)
            4'd0:    step_quality = 6'd10;
            4'd1:    step_quality = 6'd16;
            4'd2:    step_quality = 6'd12;
            4'd3:    step_quality = 6'd10;
            4'd4:    step_quality = 6'd16;
            default: step_quality = 6'd22;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- rtl/aqlc_profile.sv -----
// day/night profile selection with gain hysteresis and vote confirmation
`default_nettype none

module aqlc_profile (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic [1:0]               op,
    input  logic [7:0]               gain_low,
    input  logic [7:0]               gain_high,
    input  logic                     gain_valid,
    input  aqlc_pkg::profile_cfg_t   cfg,
    output aqlc_pkg::profile_status_t status
);
    import aqlc_pkg::*;

    logic       night_reg;
    logic       night_next;
    logic [3:0] vote_reg;
    logic [3:0] vote_next;
    logic [3:0] vote_inc;
    logic [9:0] gain;
    logic       want;
    logic       changed;
    logic [9:0] gain_seen;

    assign gain     = {gain_high[7:6], gain_low};
    assign vote_inc = (vote_reg != 4'hF) ? vote_reg + 4'd1 : vote_reg;

    always_comb
    begin
        want = night_reg;
        if (!night_reg && gain >= cfg.enter_gain)
        begin
            want = 1'b1;
        end
        else if (night_reg && gain <= cfg.exit_gain)
        begin
            want = 1'b0;
        end

        night_next = night_reg;
        vote_next  = vote_reg;
        changed    = 1'b0;
        gain_seen  = '0;
        if (op == OP_GAIN && gain_valid)
        begin
            gain_seen = gain;
            if (want != night_reg)
            begin
                if (vote_inc >= cfg.confirm)
                begin
                    night_next = want;
                    vote_next  = '0;
                    changed    = 1'b1;
                end
                else
                begin
                    vote_next = vote_inc;
                end
            end
            else
            begin
                vote_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            night_reg <= 1'b0;
            vote_reg  <= '0;
        end
        else if (adv)
        begin
            night_reg <= night_next;
            vote_reg  <= vote_next;
        end
    end

    assign status.night      = night_reg;
    assign status.night_next = night_next;
    assign status.changed    = changed;
    assign status.gain       = gain_seen;

endmodule

`default_nettype wire

// ----- rtl/aqlc_ladder.sv -----
// latency averaging and quality step selection
`default_nettype none

module aqlc_ladder #(
    parameter int LADDER_STEPS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [1:0]                    op,
    input  logic [15:0]                   latency_ms,
    input  logic                          night,
    input  aqlc_pkg::ladder_cfg_t         cfg,
    output logic [$clog2(LADDER_STEPS)-1:0] level_next,
    output logic [15:0]                   avg_next,
    output logic                          level_changed
);
    import aqlc_pkg::*;

    localparam int LVL_W = $clog2(LADDER_STEPS);
    localparam logic [LVL_W-1:0] FLOOR_LEVEL = LVL_W'(LADDER_STEPS - 1);
    localparam logic [LVL_W-1:0] RESET_LEVEL = LVL_W'(LADDER_STEPS - 2);

    logic [LVL_W-1:0] level_reg;
    logic [15:0]      avg_reg;
    logic [9:0]       clean_reg;
    logic [9:0]       clean_next;
    logic [9:0]       clean_inc;
    logic [7:0]       interval;
    logic [17:0]      avg_sum;
    logic [15:0]      avg_calc;
    logic [22:0]      avg_scaled;
    logic [17:0]      down_thr;
    logic [17:0]      up_thr;
    logic             is_down;
    logic             is_clean;

    assign interval   = night ? cfg.night_int : cfg.day_int;
    assign avg_sum    = 18'(avg_reg) * 18'd3 + 18'(latency_ms);
    assign avg_calc   = avg_sum[17:2];
    assign avg_scaled = 23'(avg_calc) * 23'(AVG_SCALE);
    assign down_thr   = 18'(interval) * 18'(cfg.down_pct);
    assign up_thr     = 18'(interval) * 18'(cfg.up_pct);
    assign is_down    = avg_scaled > 23'(down_thr);
    assign is_clean   = avg_scaled < 23'(up_thr);
    assign clean_inc  = (clean_reg < cfg.up_clean && clean_reg != 10'h3FF)
                        ? clean_reg + 10'd1 : clean_reg;

    always_comb
    begin
        level_next = level_reg;
        avg_next   = avg_reg;
        clean_next = clean_reg;
        case (op)
            OP_SEND_OK:
            begin
                avg_next = avg_calc;
                if (is_down)
                begin
                    clean_next = '0;
                    if (level_reg < FLOOR_LEVEL)
                    begin
                        level_next = level_reg + LVL_W'(1);
                    end
                end
                else if (is_clean)
                begin
                    clean_next = clean_inc;
                    if (clean_inc >= cfg.up_clean && level_reg != '0)
                    begin
                        level_next = level_reg - LVL_W'(1);
                        clean_next = '0;
                    end
                end
                else
                begin
                    clean_next = '0;
                end
            end
            OP_SEND_FAIL:
            begin
                clean_next = '0;
                avg_next   = '0;
                level_next = FLOOR_LEVEL;
            end
            default:
            begin
                level_next = level_reg;
            end
        endcase
    end

    assign level_changed = (level_next != level_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= RESET_LEVEL;
            avg_reg   <= '0;
            clean_reg <= '0;
        end
        else if (adv)
        begin
            level_reg <= level_next;
            avg_reg   <= avg_next;
            clean_reg <= clean_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/adaptive_quality_ladder_control.sv -----
// top level of the adaptive quality ladder controller
`default_nettype none

// channel   | handshake             | contents
// ----------+-----------------------+---------------------------------------------
// input     | in_valid / in_ready   | op, gain_low, gain_high, gain_valid, latency_ms
// output    | out_valid / out_ready | step, size, quality, mode, interval, average,
//           |                       | change flags, gain_seen
// config    | cfg_we                | cfg_index, cfg_data (write only, no wait)
//
// one request per cycle sustained while the result register is not stalled; each request
// passes through the input register and then leaves through the result register
// the step and profile state updates when a request moves into the result register
// a stalled result holds the input register; the input side keeps accepting while
// the result register is free or being emptied in the same cycle
// reset clears the handshake state and sets the configuration and the ladder/profile state to their reset values

module adaptive_quality_ladder_control #(
    parameter int LADDER_STEPS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    // input requests
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  gain_low,
    input  logic [7:0]  gain_high,
    input  logic        gain_valid,
    input  logic [15:0] latency_ms,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  ladder_level,
    output logic [1:0]  frame_size_code,
    output logic [5:0]  jpeg_quality,
    output logic        night_mode,
    output logic [7:0]  frame_interval,
    output logic [15:0] latency_average,
    output logic        level_changed,
    output logic        profile_changed,
    output logic [9:0]  gain_seen,
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [aqlc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import aqlc_pkg::*;

    localparam int LVL_W = $clog2(LADDER_STEPS);

    // configuration registers
    profile_cfg_t prof_cfg_reg;
    ladder_cfg_t  lad_cfg_reg;

    // input register
    logic        in_vld_reg;
    logic [1:0]  op_reg;
    logic [7:0]  gain_low_reg;
    logic [7:0]  gain_high_reg;
    logic        gain_valid_reg;
    logic [15:0] latency_reg;

    // result register
    logic        out_vld_reg;
    logic [2:0]  level_out_reg;
    logic [1:0]  size_out_reg;
    logic [5:0]  quality_out_reg;
    logic        night_out_reg;
    logic [7:0]  interval_out_reg;
    logic [15:0] avg_out_reg;
    logic        lvl_chg_out_reg;
    logic        prof_chg_out_reg;
    logic [9:0]  gain_out_reg;

    // datapath
    logic                   out_free;
    logic                   adv;
    profile_status_t        prof_status;
    logic [LVL_W-1:0]       level_next;
    logic [LEVEL_MAX_W-1:0] level_ext;
    logic [15:0]            avg_next;
    logic                   lvl_chg;
    logic                   both_chg;

    // result register is free when empty or being read this cycle
    assign out_free = !out_vld_reg || out_ready;
    assign adv      = in_vld_reg && out_free;
    assign in_ready = !in_vld_reg || out_free;

    // configuration: values keep the low bits that fit each register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prof_cfg_reg.enter_gain <= 10'd520;
            prof_cfg_reg.exit_gain  <= 10'd300;
            prof_cfg_reg.confirm    <= 4'd3;
            lad_cfg_reg.down_pct    <= 10'd150;
            lad_cfg_reg.up_pct      <= 10'd75;
            lad_cfg_reg.up_clean    <= 10'd150;
            lad_cfg_reg.day_int     <= 8'd33;
            lad_cfg_reg.night_int   <= 8'd66;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NIGHT_ENTER:    prof_cfg_reg.enter_gain <= cfg_data;
                CFG_NIGHT_EXIT:     prof_cfg_reg.exit_gain  <= cfg_data;
                CFG_NIGHT_CONFIRM:  prof_cfg_reg.confirm    <= cfg_data[3:0];
                CFG_DOWN_PCT:       lad_cfg_reg.down_pct    <= cfg_data;
                CFG_UP_PCT:         lad_cfg_reg.up_pct      <= cfg_data;
                CFG_UP_CLEAN:       lad_cfg_reg.up_clean    <= cfg_data;
                CFG_DAY_INTERVAL:   lad_cfg_reg.day_int     <= cfg_data[7:0];
                CFG_NIGHT_INTERVAL: lad_cfg_reg.night_int   <= cfg_data[7:0];
                default:            lad_cfg_reg.night_int   <= lad_cfg_reg.night_int;
            endcase
        end
    end

    // input register: loads whenever it is empty or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg         <= op;
            gain_low_reg   <= gain_low;
            gain_high_reg  <= gain_high;
            gain_valid_reg <= gain_valid;
            latency_reg    <= latency_ms;
        end
    end

    // day/night vote
    aqlc_profile u_profile (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .op         (op_reg),
        .gain_low   (gain_low_reg),
        .gain_high  (gain_high_reg),
        .gain_valid (gain_valid_reg),
        .cfg        (prof_cfg_reg),
        .status     (prof_status)
    );

    // latency average and step selection, uses the mode in force before the request
    aqlc_ladder #(
        .LADDER_STEPS (LADDER_STEPS)
    ) u_ladder (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .op            (op_reg),
        .latency_ms    (latency_reg),
        .night         (prof_status.night),
        .cfg           (lad_cfg_reg),
        .level_next    (level_next),
        .avg_next      (avg_next),
        .level_changed (lvl_chg)
    );

    assign level_ext = LEVEL_MAX_W'(level_next);

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            level_out_reg    <= level_ext[2:0];
            size_out_reg     <= step_size(level_ext);
            quality_out_reg  <= step_quality(level_ext);
            night_out_reg    <= prof_status.night_next;
            interval_out_reg <= prof_status.night_next ? lad_cfg_reg.night_int
                                                       : lad_cfg_reg.day_int;
            avg_out_reg      <= avg_next;
            lvl_chg_out_reg  <= lvl_chg;
            prof_chg_out_reg <= prof_status.changed;
            gain_out_reg     <= prof_status.gain;
        end
    end

    assign out_valid       = out_vld_reg;
    assign ladder_level    = level_out_reg;
    assign frame_size_code = size_out_reg;
    assign jpeg_quality    = quality_out_reg;
    assign night_mode      = night_out_reg;
    assign frame_interval  = interval_out_reg;
    assign latency_average = avg_out_reg;
    assign level_changed   = lvl_chg_out_reg;
    assign profile_changed = prof_chg_out_reg;
    assign gain_seen       = gain_out_reg;

    assign both_chg = lvl_chg_out_reg && prof_chg_out_reg;

    // checks
`include "adaptive_quality_ladder_control_assert.svh"

    // an empty result register never blocks the input side
    `AQLC_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_vld_reg, in_ready, "input blocked")
    // a request that moves on always lands in the result register
    `AQLC_ASSERT_NEXT(a_adv_fills_result, clk, rst_n, adv, out_vld_reg, "request lost")
    // a gain reading cannot move the step and a send cannot switch the profile
    `AQLC_ASSERT_NOW(a_single_change, clk, rst_n, out_vld_reg, !both_chg, "two changes at once")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// self-checking testbench for the adaptive quality ladder controller
module tb_top;
    import aqlc_pkg::*;

    // ------------------------------------------------------------------
    // constants of the bench
    // ------------------------------------------------------------------
    localparam int LADDER_STEPS = 6;
    localparam logic [2:0] FLOOR_STEP = 3'(LADDER_STEPS - 1);
    localparam int TOP_ROW = 5;            // last row of the ladder table
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 4;      // input and result registers plus margin
    localparam int HOLD_CYCLES = 80;       // long receiver hold-off
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 240;

    // ladder table, row 0 in the low slot
    localparam logic [5:0][1:0] SIZE_BY_STEP = {2'd2, 2'd2, 2'd2, 2'd1, 2'd0, 2'd0};
    localparam logic [5:0][5:0] QUALITY_BY_STEP =
        {6'd22, 6'd16, 6'd10, 6'd12, 6'd16, 6'd10};

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  glo;
        logic [7:0]  ghi;
        logic        gvalid;
        logic [15:0] lat;
    } ladder_req_t;

    typedef struct packed {
        logic [2:0]  level;
        logic [1:0]  size;
        logic [5:0]  quality;
        logic        night;
        logic [7:0]  interval;
        logic [15:0] avg;
        logic        lvl_chg;
        logic        prof_chg;
        logic [9:0]  gain;
    } ladder_res_t;

    // ------------------------------------------------------------------
    // block signals, inputs known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = OP_GAIN;
    logic [7:0]  gain_low = '0;
    logic [7:0]  gain_high = '0;
    logic        gain_valid = 1'b0;
    logic [15:0] latency_ms = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  ladder_level;
    logic [1:0]  frame_size_code;
    logic [5:0]  jpeg_quality;
    logic        night_mode;
    logic [7:0]  frame_interval;
    logic [15:0] latency_average;
    logic        level_changed;
    logic        profile_changed;
    logic [9:0]  gain_seen;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    adaptive_quality_ladder_control #(
        .LADDER_STEPS(LADDER_STEPS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .gain_low(gain_low),
        .gain_high(gain_high),
        .gain_valid(gain_valid),
        .latency_ms(latency_ms),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .ladder_level(ladder_level),
        .frame_size_code(frame_size_code),
        .jpeg_quality(jpeg_quality),
        .night_mode(night_mode),
        .frame_interval(frame_interval),
        .latency_average(latency_average),
        .level_changed(level_changed),
        .profile_changed(profile_changed),
        .gain_seen(gain_seen),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // mirrored configuration, reset values of the block
    // ------------------------------------------------------------------
    logic [9:0] cfg_enter = 10'd520;
    logic [9:0] cfg_exit = 10'd300;
    logic [3:0] cfg_confirm = 4'd3;
    logic [9:0] cfg_down = 10'd150;
    logic [9:0] cfg_up = 10'd75;
    logic [9:0] cfg_clean = 10'd150;
    logic [7:0] cfg_day_ms = 8'd33;
    logic [7:0] cfg_night_ms = 8'd66;

    // predicted ladder and profile state
    logic [2:0]  lvl = FLOOR_STEP - 3'd1;   // one short of the floor after reset
    logic [9:0]  clean_run = '0;
    logic [15:0] lat_avg = '0;
    logic        night_on = 1'b0;
    logic [3:0]  votes = '0;

    // request traffic and expected status results
    ladder_req_t req_pending[$];
    ladder_res_t status_due[$];
    ladder_req_t next_req;
    ladder_req_t taken_req;
    ladder_res_t due;

    logic in_taken = 1'b0;
    bit   idle_on = 1'b1;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   hold_asked = 0;
    int   hold_served = 0;
    int   errors = 0;
    int   results_checked = 0;
    int   requests_sent = 0;
    int   in_stall_cycles = 0;
    int   counted_made = 0;
    int   settings_used = 1;
    int   cycle_count = 0;

    // ------------------------------------------------------------------
    // predictor: one request in, the status it should produce out
    // ------------------------------------------------------------------
    function automatic ladder_res_t advance_ladder(input ladder_req_t r);
        ladder_res_t res;
        logic [2:0]  prior;
        logic [9:0]  g;
        logic        want;
        int unsigned ivl;
        int unsigned avg;
        int          row;
        res = '0;
        prior = lvl;
        g = '0;
        case (r.op)
            OP_GAIN:
            begin
                if (r.gvalid)
                begin
                    // only the top two bits of the high byte carry gain
                    g = {r.ghi[7:6], r.glo};
                    want = night_on;
                    if (!night_on && g >= cfg_enter)
                        want = 1'b1;
                    else if (night_on && g <= cfg_exit)
                        want = 1'b0;
                    if (want != night_on)
                    begin
                        if (votes < 4'd15)
                            votes = votes + 4'd1;
                        if (votes >= cfg_confirm)
                        begin
                            night_on = want;
                            votes = '0;
                            res.prof_chg = 1'b1;
                        end
                    end
                    else
                        votes = '0;
                end
            end
            OP_SEND_OK:
            begin
                ivl = night_on ? cfg_night_ms : cfg_day_ms;
                avg = (lat_avg * 3 + r.lat) / 4;
                lat_avg = avg[15:0];
                if (avg * 100 > ivl * cfg_down)
                begin
                    // congested: one step more conservative at once
                    clean_run = '0;
                    if (lvl < FLOOR_STEP)
                        lvl = lvl + 3'd1;
                end
                else if (avg * 100 < ivl * cfg_up)
                begin
                    // clean send: run saturates at the threshold
                    if (clean_run < cfg_clean && clean_run < 10'd1023)
                        clean_run = clean_run + 10'd1;
                    if (clean_run >= cfg_clean && lvl > 0)
                    begin
                        lvl = lvl - 3'd1;
                        clean_run = '0;
                    end
                end
                else
                    clean_run = '0;
            end
            OP_SEND_FAIL:
            begin
                clean_run = '0;
                lat_avg = '0;
                if (lvl < FLOOR_STEP)
                    lvl = FLOOR_STEP;
            end
            default: ;
        endcase
        row = (lvl < TOP_ROW) ? lvl : TOP_ROW;
        res.level = lvl;
        res.size = SIZE_BY_STEP[row];
        res.quality = QUALITY_BY_STEP[row];
        res.night = night_on;
        res.interval = night_on ? cfg_night_ms : cfg_day_ms;
        res.avg = lat_avg;
        res.lvl_chg = (lvl != prior);
        res.gain = g;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // request driver: new request at the falling edge once the last one
    // was taken, with random gaps while idling is on
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (req_pending.size() > 0)
            begin
                next_req = req_pending.pop_front();
                op <= next_req.op;
                gain_low <= next_req.glo;
                gain_high <= next_req.ghi;
                gain_valid <= next_req.gvalid;
                latency_ms <= next_req.lat;
                in_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 7);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stall bursts, plus a long hold-off on demand
    // so that the block backs up and holds its input
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 7);
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on each accepted request, check each accepted result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && !in_ready)
                in_stall_cycles++;
            if (in_valid && in_ready)
            begin
                taken_req = {op, gain_low, gain_high, gain_valid, latency_ms};
                status_due.push_back(advance_ladder(taken_req));
                requests_sent++;
            end
            if (out_valid && out_ready)
            begin
                if (status_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected, level %0d avg %0d",
                             $time, ladder_level, latency_average);
                end
                else
                begin
                    due = status_due.pop_front();
                    results_checked++;
                    check_field("ladder_level", due.level, ladder_level);
                    check_field("frame_size_code", due.size, frame_size_code);
                    check_field("jpeg_quality", due.quality, jpeg_quality);
                    check_field("night_mode", due.night, night_mode);
                    check_field("frame_interval", due.interval, frame_interval);
                    check_field("latency_average", due.avg, latency_average);
                    check_field("level_changed", due.lvl_chg, level_changed);
                    check_field("profile_changed", due.prof_chg, profile_changed);
                    check_field("gain_seen", due.gain, gain_seen);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, status_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_req(input logic [1:0] o, input logic [7:0] lo,
                            input logic [7:0] hi, input logic v, input logic [15:0] lat);
        req_pending.push_back('{o, lo, hi, v, lat});
        // ignored requests do not count towards the phase size
        if (o != OP_UNUSED && !(o == OP_GAIN && !v))
            counted_made++;
    endtask

    // gain reading; spare bits of the high byte are random
    task automatic push_gain(input int g, input logic v);
        logic [9:0] gv;
        gv = (g < 0) ? 10'd0 : (g > 1023) ? 10'd1023 : g[9:0];
        push_req(OP_GAIN, gv[7:0], {gv[9:8], 6'($urandom)}, v, 16'($urandom));
    endtask

    task automatic push_send(input int lat);
        push_req(OP_SEND_OK, 8'($urandom), 8'($urandom), 1'($urandom), lat[15:0]);
    endtask

    task automatic push_fail;
        push_req(OP_SEND_FAIL, 8'($urandom), 8'($urandom), 1'($urandom), 16'($urandom));
    endtask

    function automatic int rand_latency;
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 10);
        else if (r < 7)
            return $urandom_range(0, 300);
        else if (r < 9)
            return $urandom_range(300, 5000);
        return $urandom_range(0, 65535);
    endfunction

    // gain close to one of the two thresholds, or anywhere
    function automatic int rand_gain;
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            return cfg_enter + $urandom_range(0, 4) - 2;
        else if (r == 1)
            return cfg_exit + $urandom_range(0, 4) - 2;
        return $urandom_range(0, 1023);
    endfunction

    // random part of a phase: mostly well-formed runs with random content
    task automatic fill_phase(input int n);
        int kind;
        int len;
        int k;
        int r;
        bit to_night;
        counted_made = 0;
        while (counted_made < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
            begin
                // single loose request, noise included
                r = $urandom_range(0, 19);
                if (r == 0)
                    push_req(OP_UNUSED, 8'($urandom), 8'($urandom), 1'($urandom),
                             16'($urandom));
                else if (r < 3)
                    push_fail();
                else if (r < 10)
                    push_gain(rand_gain(), $urandom_range(0, 6) != 0);
                else
                    push_send(rand_latency());
            end
            else if (kind < 60)
            begin
                // clean run, sometimes long enough to step up
                len = cfg_clean + 1;
                if (len > 160)
                    len = 160;
                if ($urandom_range(0, 3) != 0)
                    len = $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        push_send(rand_latency());
                    else
                        push_send($urandom_range(0, 6));
                end
            end
            else if (kind < 80)
            begin
                // vote run towards one mode, now and then broken
                to_night = 1'($urandom_range(0, 1));
                len = cfg_confirm + $urandom_range(0, 2);
                if (len == 0)
                    len = 1;
                for (k = 0; k < len; k++)
                begin
                    r = $urandom_range(0, 7);
                    if (r == 0)
                        push_gain(rand_gain(), 1'b0);
                    else if (r == 1)
                        push_gain(to_night ? cfg_exit : cfg_enter, 1'b1);
                    else if (to_night)
                        push_gain(cfg_enter + $urandom_range(0, 20), 1'b1);
                    else
                        push_gain(cfg_exit - $urandom_range(0, 20), 1'b1);
                end
            end
            else if (kind < 92)
            begin
                // congestion burst
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    push_send($urandom_range(0, 1) ? $urandom_range(200, 2000)
                                                   : $urandom_range(0, 65535));
            end
            else
            begin
                // failure followed by recovery sends
                push_fail();
                len = $urandom_range(0, 3);
                for (k = 0; k < len; k++)
                    push_send($urandom_range(0, 6));
            end
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_NIGHT_ENTER:    cfg_enter = value[9:0];
            CFG_NIGHT_EXIT:     cfg_exit = value[9:0];
            CFG_NIGHT_CONFIRM:  cfg_confirm = value[3:0];
            CFG_DOWN_PCT:       cfg_down = value[9:0];
            CFG_UP_PCT:         cfg_up = value[9:0];
            CFG_UP_CLEAN:       cfg_clean = value[9:0];
            CFG_DAY_INTERVAL:   cfg_day_ms = value[7:0];
            CFG_NIGHT_INTERVAL: cfg_night_ms = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int enter_g, input int exit_g, input int confirm,
                                  input int down, input int up, input int clean,
                                  input int day_ms, input int night_ms);
        write_reg(CFG_NIGHT_ENTER, enter_g);
        write_reg(CFG_NIGHT_EXIT, exit_g);
        write_reg(CFG_NIGHT_CONFIRM, confirm);
        write_reg(CFG_DOWN_PCT, down);
        write_reg(CFG_UP_PCT, up);
        write_reg(CFG_UP_CLEAN, clean);
        write_reg(CFG_DAY_INTERVAL, day_ms);
        write_reg(CFG_NIGHT_INTERVAL, night_ms);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // settings in the working range, clean-run length chosen by the caller
    task automatic apply_random_settings(input int clean);
        int enter_g;
        enter_g = $urandom_range(300, 900);
        apply_settings(enter_g, $urandom_range(100, enter_g - 50), $urandom_range(0, 4),
                       $urandom_range(90, 300), $urandom_range(20, 95), clean,
                       $urandom_range(10, 80), $urandom_range(20, 200));
    endtask

    // block idle: no request left to drive, no result due, latency let out
    task automatic wait_idle;
        while (req_pending.size() != 0 || status_due.size() != 0 || in_valid)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed requests at reset settings
        push_req(OP_UNUSED, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);     // unused code
        push_req(OP_GAIN, 8'hFF, 8'hFF, 1'b0, 16'h0000);       // unread gain
        push_req(OP_GAIN, 8'h00, 8'h00, 1'b1, 16'hFFFF);       // agrees with day
        push_req(OP_GAIN, 8'hFF, 8'hFF, 1'b1, 16'h0000);       // three votes to night
        push_req(OP_GAIN, 8'hFF, 8'hC0, 1'b1, 16'h0000);
        push_req(OP_GAIN, 8'hFF, 8'hFF, 1'b1, 16'h0000);
        push_req(OP_GAIN, 8'h00, 8'h3F, 1'b1, 16'h0000);       // spare bits only, gain 0
        push_req(OP_GAIN, 8'h08, 8'h80, 1'b1, 16'h0000);       // 520 agrees, votes cleared
        push_req(OP_SEND_OK, 8'h00, 8'h00, 1'b0, 16'hFFFF);    // congestion to the floor
        push_req(OP_SEND_OK, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);    // floor holds
        push_req(OP_SEND_FAIL, 8'h00, 8'h00, 1'b0, 16'h0000);  // average cleared
        push_req(OP_SEND_OK, 8'h00, 8'h00, 1'b0, 16'd0);       // clean sends
        push_req(OP_SEND_OK, 8'h00, 8'h00, 1'b0, 16'd0);
        push_req(OP_SEND_OK, 8'h00, 8'h00, 1'b0, 16'd280);     // between thresholds
        push_req(OP_SEND_OK, 8'h00, 8'h00, 1'b0, 16'd0);
        push_req(OP_GAIN, 8'h2C, 8'h41, 1'b1, 16'h0000);       // exactly the exit gain
        push_req(OP_GAIN, 8'h00, 8'h00, 1'b1, 16'h0000);
        push_req(OP_GAIN, 8'h00, 8'h00, 1'b1, 16'h0000);       // back to day
        push_req(OP_SEND_FAIL, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);

        // reset settings, with a long receiver hold-off to back the block up
        hold_asked++;
        fill_phase(PHASE_ITEMS);
        wait_idle();

        // moderate settings, short clean run
        apply_settings(600, 200, 2, 150, 75, 4, 33, 66);
        fill_phase(PHASE_ITEMS);
        wait_idle();

        // every register at its top
        apply_settings(1023, 1023, 15, 1023, 1023, 1023, 255, 255);
        fill_phase(PHASE_ITEMS);
        wait_idle();

        // every register at zero: first vote switches, zero interval
        apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
        fill_phase(PHASE_ITEMS);
        wait_idle();

        // zero clean-run length with a live interval, another hold-off
        apply_random_settings(0);
        hold_asked++;
        fill_phase(PHASE_ITEMS);
        wait_idle();

        // last stretch with no idling on either side
        apply_random_settings($urandom_range(1, 6));
        idle_on = 1'b0;
        fill_phase(PHASE_ITEMS);
        wait_idle();

        $display("covered %0d requests over %0d register settings, %0d results checked",
                 requests_sent, settings_used, results_checked);
        $display("input held back for %0d cycles by result back-pressure", in_stall_cycles);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
